// File: hdl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and constants for the scalar Kalman smoother.
// ----------------------------------------------------------------------------
package sks_pkg;

    // field widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned CFG_IDX_W = 2;

    // fixed point constants, Q1.16 / Q0.16
    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0]       HALF_Q16 = 16'h8000;

    // divider runs one quotient bit per step below the integer bit
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd2;

    // configuration reset values
    localparam logic [DATA_W-1:0] MEAS_NOISE_RST = 32'd65536;
    localparam logic [DATA_W-1:0] INIT_ERR_RST   = 32'd65536;
    localparam logic [DATA_W-1:0] PROC_NOISE_RST = 32'd655;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_MAG_GAIN     = 2'd0,
        MUL_ERR_GAIN     = 2'd1,
        MUL_CHANGE_NOISE = 2'd2
    } mul_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     change_en;
        logic     est_en;
        logic     finish;
    } sks_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } sks_status_t;

endpackage

// File: hdl/sks_meas_if.sv
// ----------------------------------------------------------------------------
// sks_meas_if
// Measurement channel: valid/ready handshake with one sensor sample.
// ----------------------------------------------------------------------------
interface sks_meas_if;

    logic                       valid;
    logic                       ready;
    logic signed [sks_pkg::DATA_W-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);

endinterface

// File: hdl/sks_result_if.sv
// ----------------------------------------------------------------------------
// sks_result_if
// Result channel: valid/ready handshake with estimate, gain and error.
// ----------------------------------------------------------------------------
interface sks_result_if;

    logic                              valid;
    logic                              ready;
    logic signed [sks_pkg::DATA_W-1:0] estimate;
    logic [sks_pkg::GAIN_W-1:0]        gain;
    logic [sks_pkg::DATA_W-1:0]        estimate_error;

    modport source (output valid, output estimate, output gain, output estimate_error,
                    input ready);
    modport sink   (input valid, input estimate, input gain, input estimate_error,
                    output ready);

endinterface

// File: hdl/scalar_kalman_smoother.sv
// A measurement is accepted only when idle, so words do not overlap; each runs
// the 16-step serial gain divider followed by three passes through the one
// shared multiplier, then waits until the output register is free.
// A finished result waits in the output register while the next word starts.
// Reset: estimate clears to zero, configuration takes its defaults and the
// error level loads the initial error default; no clearing pass is needed.
// ----------------------------------------------------------------------------
// scalar_kalman_smoother
// One-dimensional Kalman smoother in Q16.16 fixed point for one sensor stream.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother (
    input  logic                              clk,
    input  logic                              rst_n,
    sks_meas_if.sink                          meas_in,
    sks_result_if.source                      result_out,
    input  logic                              cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sks_pkg::DATA_W-1:0]        cfg_data
);

    sks_pkg::sks_cmd_t    cmd;
    sks_pkg::sks_status_t status;

    // sequencer
    sks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (meas_in.valid),
        .in_ready (meas_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    sks_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .measurement  (meas_in.measurement),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (result_out.valid),
        .out_ready    (result_out.ready),
        .out_estimate (result_out.estimate),
        .out_gain     (result_out.gain),
        .out_error    (result_out.estimate_error)
    );

endmodule

// File: hdl/sks_ctrl.sv
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer: accepts a word, runs the serial divider, then the three
// multiply steps on the shared multiplier and writes the result.
// ----------------------------------------------------------------------------
module sks_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sks_pkg::sks_status_t status,
    output sks_pkg::sks_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_DIV       = 6'b000010,
        ST_MUL_DELTA = 6'b000100,
        ST_CHANGE    = 6'b001000,
        ST_MUL_NOISE = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [sks_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [sks_pkg::DIV_CNT_W-1:0]  cnt_next;

    localparam logic [sks_pkg::DIV_CNT_W-1:0] CNT_LAST =
        sks_pkg::DIV_CNT_W'(sks_pkg::DIV_STEPS - 1);

    // state register and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = sks_pkg::MUL_MAG_GAIN;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_MUL_DELTA;
                end
            end
            ST_MUL_DELTA:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sks_pkg::MUL_MAG_GAIN;
                state_next  = ST_CHANGE;
            end
            ST_CHANGE:
            begin
                cmd.change_en = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = sks_pkg::MUL_ERR_GAIN;
                state_next    = ST_MUL_NOISE;
            end
            ST_MUL_NOISE:
            begin
                cmd.est_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sks_pkg::MUL_CHANGE_NOISE;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sks_datapath.sv
// ----------------------------------------------------------------------------
// sks_datapath
// Filter state, configuration registers, restoring divider for the gain,
// shared multiplier with rounding, and the output register.
// ----------------------------------------------------------------------------
module sks_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sks_pkg::sks_cmd_t                    cmd,
    output sks_pkg::sks_status_t                 status,
    input  logic signed [sks_pkg::DATA_W-1:0]    measurement,
    input  logic                                 cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sks_pkg::DATA_W-1:0]           cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sks_pkg::DATA_W-1:0]    out_estimate,
    output logic [sks_pkg::GAIN_W-1:0]           out_gain,
    output logic [sks_pkg::DATA_W-1:0]           out_error
);

    localparam int unsigned W = sks_pkg::DATA_W;
    localparam int unsigned G = sks_pkg::GAIN_W;

    // configuration
    logic [W-1:0]        meas_noise_reg;
    logic [W-1:0]        proc_noise_reg;

    // filter state
    logic signed [W-1:0] last_est_reg;
    logic [W-1:0]        err_reg;
    logic [W-1:0]        err_next;

    // per-word working registers
    logic [W:0]          mag_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic [W:0]          sum_reg;
    logic [W:0]          rem_reg;
    logic [G-1:0]        quot_reg;
    logic [2*W-1:0]      prod_reg;
    logic [W:0]          change_reg;
    logic [W-1:0]        t1_reg;
    logic signed [W-1:0] new_est_reg;

    // output register
    logic                out_valid_reg;
    logic signed [W-1:0] out_est_reg;
    logic [G-1:0]        out_gain_reg;
    logic [W-1:0]        out_err_reg;

    logic [G-1:0]        gain;
    logic [W+1:0]        rem_dbl;
    logic                rem_ge;
    logic [W:0]          rem_next;
    logic [W:0]          mul_a;
    logic [W-1:0]        mul_b;
    logic [2*W-1:0]      mul_p;
    logic [2*W:0]        prod_rnd;
    logic [2*W-16:0]     prod_q;
    logic [2*W-14:0]     total_wide;
    logic [W-1:0]        total_sat;
    logic [W:0]          diff_pos;
    logic [W:0]          diff_neg;
    logic                meas_lt;

    // gain is forced to zero when err and noise are both zero
    assign gain = zero_reg ? '0 : quot_reg;

    // magnitude of measurement minus last estimate
    assign meas_lt  = measurement < last_est_reg;
    assign diff_pos = (W+1)'(signed'({measurement[W-1], measurement})
                             - signed'({last_est_reg[W-1], last_est_reg}));
    assign diff_neg = (W+1)'(signed'({last_est_reg[W-1], last_est_reg})
                             - signed'({measurement[W-1], measurement}));

    // one restoring division step
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_ge   = rem_dbl >= {1'b0, sum_reg};
    assign rem_next = rem_ge ? (W+1)'(rem_dbl - {1'b0, sum_reg}) : rem_dbl[W:0];

    // shared multiplier operands; the top bit of a is set only for 2^32 exactly
    always_comb
    begin
        unique case (cmd.mul_sel)
            sks_pkg::MUL_MAG_GAIN:
            begin
                mul_a = mag_reg;
                mul_b = W'(gain);
            end
            sks_pkg::MUL_ERR_GAIN:
            begin
                mul_a = (W+1)'(sks_pkg::ONE_Q16 - gain);
                mul_b = err_reg;
            end
            sks_pkg::MUL_CHANGE_NOISE:
            begin
                mul_a = change_reg;
                mul_b = proc_noise_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a[W] ? {mul_b, {W{1'b0}}} : (2*W)'(mul_a[W-1:0] * mul_b);

    // round half up and drop sixteen fraction bits
    assign prod_rnd = {1'b0, prod_reg} + (2*W+1)'(sks_pkg::HALF_Q16);
    assign prod_q   = prod_rnd[2*W:16];

    // error sum with saturation
    assign total_wide = (2*W-13)'(t1_reg) + (2*W-13)'(prod_q);
    assign total_sat  = (|total_wide[2*W-14:W]) ? {W{1'b1}} : total_wide[W-1:0];

    // configuration registers; the initial error goes straight to the error level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_noise_reg <= sks_pkg::MEAS_NOISE_RST;
            proc_noise_reg <= sks_pkg::PROC_NOISE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sks_pkg::CFG_MEAS_NOISE: meas_noise_reg <= cfg_data;
                sks_pkg::CFG_PROC_NOISE: proc_noise_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // error level: reloaded by a write of the initial error register, which wins over the update of a finished word
    always_comb
    begin
        err_next = err_reg;
        priority if (cfg_we && (cfg_index == sks_pkg::CFG_INIT_ERR))
        begin
            err_next = cfg_data;
        end
        else if (cmd.finish)
        begin
            err_next = total_sat;
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_est_reg <= '0;
            err_reg      <= sks_pkg::INIT_ERR_RST;
        end
        else
        begin
            err_reg <= err_next;
            if (cmd.finish)
            begin
                last_est_reg <= new_est_reg;
            end
        end
    end

    // working registers of one word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= meas_lt;
            mag_reg  <= meas_lt ? diff_neg : diff_pos;
            zero_reg <= (err_reg == '0) && (meas_noise_reg == '0);
            sum_reg  <= {1'b0, err_reg} + {1'b0, meas_noise_reg};
            // integer quotient bit is set only when the noise is zero
            rem_reg  <= (meas_noise_reg == '0) ? '0 : {1'b0, err_reg};
            quot_reg <= {{(G-1){1'b0}}, meas_noise_reg == '0};
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[G-2:0], rem_ge};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.change_en)
        begin
            change_reg <= prod_q[W:0];
        end
        if (cmd.est_en)
        begin
            t1_reg      <= prod_q[W-1:0];
            new_est_reg <= neg_reg ? last_est_reg - signed'(change_reg[W-1:0])
                                   : last_est_reg + signed'(change_reg[W-1:0]);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_est_reg  <= new_est_reg;
            out_gain_reg <= gain;
            out_err_reg  <= total_sat;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_estimate    = out_est_reg;
    assign out_gain        = out_gain_reg;
    assign out_error       = out_err_reg;

endmodule
